// ===== sv/uttc_pkg.sv =====
// Shared types, widths and arithmetic constants of the Unix-time-to-calendar unit.
package uttc_pkg;

  // Pipeline depths
  localparam int unsigned SPLIT_STAGES = 2;
  localparam int unsigned DATE_STAGES  = 11;
  localparam int unsigned LATENCY      = SPLIT_STAGES + DATE_STAGES;
  // time-of-day result plus its delay taps, aligned to the date path
  localparam int unsigned TOD_LINE     = DATE_STAGES - 3;

  typedef logic [30:0] secs_t;
  typedef logic [14:0] days_t;
  typedef logic [16:0] rem_t;
  typedef logic [10:0] year_t;
  typedef logic [3:0]  month_t;
  typedef logic [4:0]  mday_t;
  typedef logic [4:0]  hour_t;
  typedef logic [5:0]  minute_t;
  typedef logic [5:0]  second_t;

  typedef struct packed {
    hour_t   hour;
    minute_t minute;
    second_t second;
  } tod_t;

  // seconds / 86400 == (seconds >> 7) / 675
  localparam logic [9:0]  DAY_Q       = 10'd675;
  localparam logic [24:0] RECIP_675   = 25'd25451658;   // floor(2^34 / 675)
  localparam logic [5:0]  SIXTY       = 6'd60;
  localparam logic [18:0] RECIP_60    = 19'd279620;     // floor(2^24 / 60)

  localparam logic [21:0] EPOCH_DAY   = 22'd2440588;
  localparam logic [21:0] REFORM_DAY  = 22'd2299161;
  localparam logic [21:0] ALPHA_BIAS  = 22'd2293487;    // 4 * EPOCH_DAY - 7468865
  localparam logic [17:0] ALPHA_DIV   = 18'd146097;
  localparam logic [14:0] RECIP_ALPHA = 15'd29398;      // floor(2^32 / 146097)
  localparam logic [10:0] B_OFS       = 11'd1524;
  localparam logic [11:0] C_BIAS      = 12'd2442;
  localparam logic [12:0] C_DIV       = 13'd7305;
  localparam logic [25:0] RECIP_C     = 26'd37628734;   // floor(2^38 / 7305)
  localparam logic [10:0] QUAD_DAYS   = 11'd1461;
  localparam logic [13:0] E_SCALE     = 14'd10000;
  localparam logic [18:0] E_DIV       = 19'd306001;
  localparam logic [27:0] RECIP_E     = 28'd140350000;  // 10000 * floor(2^32 / 306001)
  localparam logic [3:0]  MONTH_WRAP  = 4'd14;
  localparam logic [3:0]  FEBRUARY    = 4'd2;
  localparam logic [13:0] YEAR_BIAS   = 14'd4716;

  // floor(30.6001 * e)
  function automatic logic [8:0] month_offset(input logic [3:0] e);
    logic [8:0] v;
    case (e)
      4'd0:  v = 9'd0;
      4'd1:  v = 9'd30;
      4'd2:  v = 9'd61;
      4'd3:  v = 9'd91;
      4'd4:  v = 9'd122;
      4'd5:  v = 9'd153;
      4'd6:  v = 9'd183;
      4'd7:  v = 9'd214;
      4'd8:  v = 9'd244;
      4'd9:  v = 9'd275;
      4'd10: v = 9'd306;
      4'd11: v = 9'd336;
      4'd12: v = 9'd367;
      4'd13: v = 9'd397;
      4'd14: v = 9'd428;
      4'd15: v = 9'd459;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/uttc_if.sv =====
// Handshake channels of the Unix-time-to-calendar unit.
interface uttc_stamp_if;
  logic                 valid;
  logic                 ready;
  uttc_pkg::secs_t      seconds_since_epoch;

  modport source (output valid, output seconds_since_epoch, input ready);
  modport sink   (input valid, input seconds_since_epoch, output ready);
endinterface

interface uttc_calendar_if;
  logic                 valid;
  logic                 ready;
  uttc_pkg::year_t      year;
  uttc_pkg::month_t     month;
  uttc_pkg::mday_t      day_of_month;
  uttc_pkg::hour_t      hour;
  uttc_pkg::minute_t    minute;
  uttc_pkg::second_t    second;

  modport source (output valid, output year, output month, output day_of_month,
                  output hour, output minute, output second, input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input hour, input minute, input second, output ready);
endinterface

// ===== sv/uttc_split.sv =====
// Two-stage split of a timestamp into whole days and seconds of the day.
module uttc_split (
  input  logic            clk,
  input  logic            advance,
  input  uttc_pkg::secs_t secs,
  output uttc_pkg::days_t days,
  output uttc_pkg::rem_t  rem
);

  logic [48:0]     prod;
  logic [23:0]     q1;
  uttc_pkg::days_t est1;
  logic [6:0]      lo1;

  logic [23:0]     back;
  logic [23:0]     diff;
  logic [10:0]     r;
  logic            over;
  logic [10:0]     r_fix;

  assign prod = 49'(secs[30:7]) * 49'(uttc_pkg::RECIP_675);

  always_ff @(posedge clk) begin
    if (advance) begin
      q1   <= secs[30:7];
      est1 <= prod[48:34];
      lo1  <= secs[6:0];
    end
  end

  // estimate is low by at most one
  assign back  = 24'(est1) * 24'(uttc_pkg::DAY_Q);
  assign diff  = q1 - back;
  assign r     = diff[10:0];
  assign over  = r >= 11'(uttc_pkg::DAY_Q);
  assign r_fix = over ? r - 11'(uttc_pkg::DAY_Q) : r;

  always_ff @(posedge clk) begin
    if (advance) begin
      days <= over ? est1 + 15'd1 : est1;
      rem  <= {r_fix[9:0], lo1};
    end
  end

endmodule

// ===== sv/uttc_tod.sv =====
// Hour, minute and second from the seconds of the day, delayed to match the date path.
module uttc_tod (
  input  logic           clk,
  input  logic           advance,
  input  uttc_pkg::rem_t rem,
  output uttc_pkg::tod_t tod
);

  logic [35:0]          p1;
  logic [10:0]          mest1;
  uttc_pkg::rem_t       rem1;

  logic [16:0]          back2;
  logic [16:0]          diff2;
  logic [6:0]           r2;
  logic                 over2;
  logic [10:0]          mins2;
  uttc_pkg::second_t    sec2;

  logic [29:0]          p3;
  uttc_pkg::hour_t      hest3;
  logic [10:0]          mins3;
  uttc_pkg::second_t    sec3;

  logic [10:0]          back4;
  logic [10:0]          diff4;
  logic [6:0]           r4;
  logic                 over4;
  uttc_pkg::tod_t       tod_next;

  uttc_pkg::tod_t [uttc_pkg::TOD_LINE-1:0] line;

  assign p1 = 36'(rem) * 36'(uttc_pkg::RECIP_60);

  always_ff @(posedge clk) begin
    if (advance) begin
      mest1 <= p1[34:24];
      rem1  <= rem;
    end
  end

  assign back2 = 17'(mest1) * 17'(uttc_pkg::SIXTY);
  assign diff2 = rem1 - back2;
  assign r2    = diff2[6:0];
  assign over2 = r2 >= 7'(uttc_pkg::SIXTY);

  always_ff @(posedge clk) begin
    if (advance) begin
      mins2 <= over2 ? mest1 + 11'd1 : mest1;
      sec2  <= over2 ? 6'(r2 - 7'(uttc_pkg::SIXTY)) : r2[5:0];
    end
  end

  assign p3 = 30'(mins2) * 30'(uttc_pkg::RECIP_60);

  always_ff @(posedge clk) begin
    if (advance) begin
      hest3 <= p3[28:24];
      mins3 <= mins2;
      sec3  <= sec2;
    end
  end

  assign back4 = 11'(hest3) * 11'(uttc_pkg::SIXTY);
  assign diff4 = mins3 - back4;
  assign r4    = diff4[6:0];
  assign over4 = r4 >= 7'(uttc_pkg::SIXTY);

  always_comb begin
    tod_next.hour   = over4 ? hest3 + 5'd1 : hest3;
    tod_next.minute = over4 ? 6'(r4 - 7'(uttc_pkg::SIXTY)) : r4[5:0];
    tod_next.second = sec3;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      line <= {line[uttc_pkg::TOD_LINE-2:0], tod_next};
    end
  end

  assign tod = line[uttc_pkg::TOD_LINE-1];

endmodule

// ===== sv/uttc_date.sv =====
// Eleven-stage Julian-day-to-Gregorian-date pipeline.
module uttc_date (
  input  logic              clk,
  input  logic              advance,
  input  uttc_pkg::days_t   days,
  output uttc_pkg::year_t   year,
  output uttc_pkg::month_t  month,
  output uttc_pkg::mday_t   day_of_month
);

  // stage 1: day number and alpha numerator
  logic [21:0] z_d;
  logic [21:0] numer1, z1;
  logic        pre1;
  // stage 2: alpha estimate
  logic [36:0] p2;
  logic [4:0]  aest2;
  logic [21:0] numer2, z2;
  logic        pre2;
  // stage 3: alpha corrected
  logic [21:0] back3, r3;
  logic [4:0]  alpha3;
  logic [21:0] z3;
  logic        pre3;
  // stage 4: b
  logic [21:0] b4;
  // stage 5: 20b - 2442
  logic [25:0] n5;
  logic [21:0] b5;
  // stage 6: c estimate
  logic [51:0] p6;
  logic [13:0] cest6;
  logic [25:0] n6;
  logic [21:0] b6;
  // stage 7: c corrected
  logic [25:0] back7, r7;
  logic [13:0] c7;
  logic [21:0] b7;
  // stage 8: day of the shifted year
  logic [24:0] d8;
  logic [8:0]  x8;
  logic [13:0] c8;
  // stage 9: e estimate
  logic [36:0] p9;
  logic [3:0]  eest9;
  logic [8:0]  x9;
  logic [13:0] c9;
  // stage 10: e corrected
  logic [22:0] num10, back10, r10;
  logic [3:0]  e10;
  logic [8:0]  x10;
  logic [13:0] c10;
  // stage 11: fields
  uttc_pkg::month_t mon;

  assign z_d = 22'(days) + uttc_pkg::EPOCH_DAY;

  always_ff @(posedge clk) begin
    if (advance) begin
      numer1 <= 22'({days, 2'b00}) + uttc_pkg::ALPHA_BIAS;
      z1     <= z_d;
      pre1   <= z_d < uttc_pkg::REFORM_DAY;
    end
  end

  assign p2 = 37'(numer1) * 37'(uttc_pkg::RECIP_ALPHA);

  always_ff @(posedge clk) begin
    if (advance) begin
      aest2  <= p2[36:32];
      numer2 <= numer1;
      z2     <= z1;
      pre2   <= pre1;
    end
  end

  assign back3 = 22'(aest2) * 22'(uttc_pkg::ALPHA_DIV);
  assign r3    = numer2 - back3;

  always_ff @(posedge clk) begin
    if (advance) begin
      alpha3 <= (r3 >= 22'(uttc_pkg::ALPHA_DIV)) ? aest2 + 5'd1 : aest2;
      z3     <= z2;
      pre3   <= pre2;
    end
  end

  // before the reform day no Gregorian correction
  always_ff @(posedge clk) begin
    if (advance) begin
      b4 <= pre3 ? z3 + 22'(uttc_pkg::B_OFS)
                 : z3 + 22'(uttc_pkg::B_OFS) + 22'd1 + 22'(alpha3) - 22'(alpha3[4:2]);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      n5 <= 26'({b4, 4'b0000}) + 26'({b4, 2'b00}) - 26'(uttc_pkg::C_BIAS);
      b5 <= b4;
    end
  end

  assign p6 = 52'(n5) * 52'(uttc_pkg::RECIP_C);

  always_ff @(posedge clk) begin
    if (advance) begin
      cest6 <= p6[51:38];
      n6    <= n5;
      b6    <= b5;
    end
  end

  assign back7 = 26'(cest6) * 26'(uttc_pkg::C_DIV);
  assign r7    = n6 - back7;

  always_ff @(posedge clk) begin
    if (advance) begin
      c7 <= (r7 >= 26'(uttc_pkg::C_DIV)) ? cest6 + 14'd1 : cest6;
      b7 <= b6;
    end
  end

  assign d8 = 25'(c7) * 25'(uttc_pkg::QUAD_DAYS);

  always_ff @(posedge clk) begin
    if (advance) begin
      x8 <= 9'(b7 - 22'(d8[24:2]));
      c8 <= c7;
    end
  end

  assign p9 = 37'(x8) * 37'(uttc_pkg::RECIP_E);

  always_ff @(posedge clk) begin
    if (advance) begin
      eest9 <= p9[35:32];
      x9    <= x8;
      c9    <= c8;
    end
  end

  assign num10  = 23'(x9) * 23'(uttc_pkg::E_SCALE);
  assign back10 = 23'(eest9) * 23'(uttc_pkg::E_DIV);
  assign r10    = num10 - back10;

  always_ff @(posedge clk) begin
    if (advance) begin
      e10 <= (r10 >= 23'(uttc_pkg::E_DIV)) ? eest9 + 4'd1 : eest9;
      x10 <= x9;
      c10 <= c9;
    end
  end

  // e counts months from March; wrap into January and February
  assign mon = (e10 < uttc_pkg::MONTH_WRAP) ? e10 - 4'd1 : e10 - 4'd13;

  always_ff @(posedge clk) begin
    if (advance) begin
      day_of_month <= 5'(x10 - uttc_pkg::month_offset(e10));
      month        <= mon;
      year         <= (mon > uttc_pkg::FEBRUARY) ? 11'(c10 - uttc_pkg::YEAR_BIAS)
                                                 : 11'(c10 - uttc_pkg::YEAR_BIAS + 14'd1);
    end
  end

endmodule

// ===== sv/unix_time_to_calendar_unit.sv =====
// Top level: Unix seconds to Gregorian date and time of day, fully pipelined.
//
//   channel   | dir | payload
//   ----------+-----+-------------------------------------------------------
//   stamp     | in  | seconds_since_epoch[30:0]
//   calendar  | out | year[10:0] month[3:0] day_of_month[4:0] hour minute second
//
// One item per cycle while the sink keeps taking results; 2 split stages, 11 date stages,
// and the time of day runs alongside and is delayed to match.
// Every divide is a reciprocal multiply corrected by one step in the next stage.
// A stall freezes all stages together when the last stage holds an item the
// sink has not taken; ready stays high otherwise, bubbles included.
// Reset clears only the valid bits.
module unix_time_to_calendar_unit (
  input  logic               clk,
  input  logic               rst,
  uttc_stamp_if.sink         stamp,
  uttc_calendar_if.source    calendar
);

  logic [uttc_pkg::LATENCY-1:0] vld;
  logic                         advance;
  uttc_pkg::days_t              days;
  uttc_pkg::rem_t               rem;
  uttc_pkg::tod_t               tod;

  assign advance     = !vld[uttc_pkg::LATENCY-1] || calendar.ready;
  assign stamp.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[uttc_pkg::LATENCY-2:0], stamp.valid};
    end
  end

  uttc_split u_split (
    .clk     (clk),
    .advance (advance),
    .secs    (stamp.seconds_since_epoch),
    .days    (days),
    .rem     (rem)
  );

  uttc_date u_date (
    .clk          (clk),
    .advance      (advance),
    .days         (days),
    .year         (calendar.year),
    .month        (calendar.month),
    .day_of_month (calendar.day_of_month)
  );

  uttc_tod u_tod (
    .clk     (clk),
    .advance (advance),
    .rem     (rem),
    .tod     (tod)
  );

  assign calendar.valid  = vld[uttc_pkg::LATENCY-1];
  assign calendar.hour   = tod.hour;
  assign calendar.minute = tod.minute;
  assign calendar.second = tod.second;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !stamp.ready |-> calendar.valid && !calendar.ready)
    else $error("input held off without a blocked result");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    calendar.valid |-> calendar.month >= 4'd1 && calendar.month <= 4'd12)
    else $error("month out of range");

  a_mday_nonzero: assert property (@(posedge clk) disable iff (rst)
    calendar.valid |-> calendar.day_of_month != 5'd0)
    else $error("day of month is zero");

  a_tod_range: assert property (@(posedge clk) disable iff (rst)
    calendar.valid |-> calendar.hour <= 5'd23 && calendar.minute <= 6'd59 &&
                       calendar.second <= 6'd59)
    else $error("time of day out of range");

  a_year_range: assert property (@(posedge clk) disable iff (rst)
    calendar.valid |-> calendar.year >= 11'd1970 && calendar.year <= 11'd2038)
    else $error("year out of range");
`endif

endmodule
